// ===== hw/rtl/slm_pkg.sv =====
package slm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MERGE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_PICK,
    S_EMPTY
  } state_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic init;
    logic pick;
    logic emit_empty;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic lists_empty;
    logic pick_last;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/slm_ram.sv =====
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/slm_datapath.sv =====
module slm_datapath import slm_pkg::*; #(
  parameter int LIST_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] merged_value,
  output logic               last,
  output logic               empty_res,
  output logic               overflow
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic [CW-1:0] ia;
  logic [CW-1:0] ib;
  logic          dropped_flag;
  logic [31:0]   rd_a;
  logic [31:0]   rd_b;
  logic          we_a;
  logic          we_b;
  logic          a_has;
  logic          b_has;
  logic          take_a;

  assign we_a = cmd.load_a && (count_a != FULL);
  assign we_b = cmd.load_b && (count_b != FULL);

  slm_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[AW-1:0]),
    .wdata (value),
    .raddr (ia[AW-1:0]),
    .rdata (rd_a)
  );

  slm_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[AW-1:0]),
    .wdata (value),
    .raddr (ib[AW-1:0]),
    .rdata (rd_b)
  );

  always_comb begin
    a_has  = ia < count_a;
    b_has  = ib < count_b;
    take_a = a_has && (!b_has || ($signed(rd_a) < $signed(rd_b)));
    sts.lists_empty = (count_a == '0) && (count_b == '0);
    sts.out_free    = !out_valid || !out_stall;
    if (take_a) begin
      sts.pick_last = ((ia + CW'(1)) == count_a) && !b_has;
    end else begin
      sts.pick_last = ((ib + CW'(1)) == count_b) && !a_has;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a      <= '0;
      count_b      <= '0;
      dropped_flag <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (we_a) begin
        count_a <= count_a + CW'(1);
      end
      if (we_b) begin
        count_b <= count_b + CW'(1);
      end
      if ((cmd.load_a && !we_a) || (cmd.load_b && !we_b)) begin
        dropped_flag <= 1'b1;
      end
      if (cmd.clear) begin
        count_a      <= '0;
        count_b      <= '0;
        dropped_flag <= 1'b0;
      end
      if (cmd.pick || cmd.emit_empty) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      ia <= '0;
      ib <= '0;
    end else if (cmd.pick) begin
      if (take_a) begin
        ia <= ia + CW'(1);
      end else begin
        ib <= ib + CW'(1);
      end
    end
    if (cmd.pick) begin
      merged_value <= take_a ? rd_a : rd_b;
      last         <= sts.pick_last;
      empty_res    <= 1'b0;
      overflow     <= dropped_flag;
    end else if (cmd.emit_empty) begin
      merged_value <= '0;
      last         <= 1'b1;
      empty_res    <= 1'b1;
      overflow     <= dropped_flag;
    end
  end

endmodule

// ===== hw/rtl/slm_ctrl.sv =====
module slm_ctrl import slm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  status_t    sts,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(op))
            OP_LOAD_A: cmd.load_a = 1'b1;
            OP_LOAD_B: cmd.load_b = 1'b1;
            OP_MERGE: begin
              if (sts.lists_empty) begin
                state_next = S_EMPTY;
              end else begin
                cmd.init   = 1'b1;
                state_next = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: state_next = S_PICK;
      S_PICK: begin
        if (sts.out_free) begin
          cmd.pick = 1'b1;
          if (sts.pick_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          cmd.clear      = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/sorted_list_merge.sv =====
// Two-way merge of sorted lists. Each load request (op 0 for list A, op 1
// for list B) writes the value into that list's RAM; a load into a full
// list is dropped and sets a sticky overflow flag. A merge request (op 2)
// stalls the input until the run is done and emits one result per step;
// each step presents the two head addresses to the registered-read RAMs
// in S_FETCH and compares the registered heads in S_PICK, where it waits
// while the output is stalled. On equal heads the list B value goes
// first. With both lists empty a single result with empty_res set is
// given. The last result carries last, every result carries the overflow
// flag, and both lists and the flag clear when the run ends. Op 3 is
// accepted and ignored.
module sorted_list_merge import slm_pkg::*; #(
  parameter int LIST_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] merged_value,
  output logic               last,
  output logic               empty_res,
  output logic               overflow
);

  cmd_t    cmd;
  status_t sts;

  slm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .sts      (sts),
    .cmd      (cmd)
  );

  slm_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .merged_value (merged_value),
    .last         (last),
    .empty_res    (empty_res),
    .overflow     (overflow)
  );

endmodule

// ===== dv/sorted_list_merge_test.sv =====
module sorted_list_merge_test;
  import slm_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int HANG_LIMIT = 5000;
  localparam int ITEM_TARGET = 270;
  localparam int VMIN = 32'sh8000_0000;
  localparam int VMAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [31:0] merged_value;
    logic last;
    logic empty_res;
    logic overflow;
  } merge_out_t;

  class merge_scoreboard;
    int list_a[$];
    int list_b[$];
    bit dropped;
    merge_out_t pending[$];
    int errors;

    // Each accepted load or merge request updates the list model; a merge request queues its results.
    function void note_request(op_t code, int val);
      merge_out_t r;
      int ia;
      int ib;
      int total;
      case (code)
        OP_LOAD_A: begin
          if (list_a.size() < LIST_DEPTH) list_a.push_back(val);
          else dropped = 1'b1;
        end
        OP_LOAD_B: begin
          if (list_b.size() < LIST_DEPTH) list_b.push_back(val);
          else dropped = 1'b1;
        end
        OP_MERGE: begin
          total = list_a.size() + list_b.size();
          r.overflow = dropped;
          if (total == 0) begin
            r.merged_value = 0;
            r.last = 1'b1;
            r.empty_res = 1'b1;
            pending.push_back(r);
          end
          ia = 0;
          ib = 0;
          for (int k = 0; k < total; k++) begin
            if (ib >= list_b.size() || (ia < list_a.size() && list_a[ia] < list_b[ib])) begin
              r.merged_value = list_a[ia];
              ia++;
            end else begin
              r.merged_value = list_b[ib];
              ib++;
            end
            r.last = (k == total - 1);
            r.empty_res = 1'b0;
            pending.push_back(r);
          end
          list_a.delete();
          list_b.delete();
          dropped = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [31:0] mv, logic lst, logic emp, logic ovf);
      merge_out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: merged_value %0d last %0b", mv, lst);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (mv !== want.merged_value) begin
        $error("merged_value: expected %0d, got %0d", want.merged_value, mv);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, lst);
        errors++;
      end
      if (emp !== want.empty_res) begin
        $error("empty_res: expected %0b, got %0b", want.empty_res, emp);
        errors++;
      end
      if (ovf !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  op_t op = OP_NONE;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] merged_value;
  logic last;
  logic empty_res;
  logic overflow;

  merge_scoreboard sb = new();
  int sent_items = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  sorted_list_merge uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .merged_value(merged_value),
    .last(last),
    .empty_res(empty_res),
    .overflow(overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(merged_value, last, empty_res, overflow);
    end
    if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 28);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == HANG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_request(op_t code, int val);
    while (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(code, val);
    if (code != OP_NONE) sent_items++;
  endtask

  // Loads two lists in a random interleaving, with a stray ignored request now and then,
  // and then requests the merge.
  task automatic run_merge_set(int na, int nb, int mode, bit ordered);
    int qa[$];
    int qb[$];
    int v;
    for (int i = 0; i < na + nb; i++) begin
      case (mode)
        0: v = $urandom;
        1: v = int'($urandom_range(8)) - 4;
        default: begin
          v = $urandom_range(1) ? ($urandom_range(1) ? VMIN : VMAX)
                                : int'($urandom_range(2)) - 1;
        end
      endcase
      if (i < na) qa.push_back(v);
      else qb.push_back(v);
    end
    if (ordered) begin
      qa.sort();
      qb.sort();
    end
    while (qa.size() + qb.size() > 0) begin
      if ($urandom_range(99) < 3) send_request(OP_NONE, $urandom);
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(1) == 0)) begin
        send_request(OP_LOAD_A, qa.pop_front());
      end else begin
        send_request(OP_LOAD_B, qb.pop_front());
      end
    end
    send_request(OP_MERGE, $urandom);
  endtask

  initial begin
    int na;
    int nb;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_MERGE, 0);
    send_request(OP_NONE, VMAX);
    send_request(OP_LOAD_A, VMIN);
    send_request(OP_LOAD_B, VMIN);
    send_request(OP_LOAD_A, -1);
    send_request(OP_LOAD_B, 0);
    send_request(OP_LOAD_A, VMAX);
    send_request(OP_LOAD_B, VMAX);
    send_request(OP_MERGE, VMIN);
    send_request(OP_LOAD_A, 7);
    send_request(OP_LOAD_A, 9);
    send_request(OP_MERGE, -1);
    send_request(OP_LOAD_B, -4);
    send_request(OP_MERGE, 0);
    send_request(OP_LOAD_A, 5);
    send_request(OP_LOAD_A, 1);
    send_request(OP_LOAD_B, 3);
    send_request(OP_MERGE, 0);
    send_request(OP_NONE, VMIN);

    while (sent_items < ITEM_TARGET) begin
      steady = (sent_items >= 120 && sent_items < 170);
      na = $urandom_range(0, 8);
      nb = $urandom_range(0, 8);
      if ($urandom_range(99) < 8) na = $urandom_range(30, 35);
      if ($urandom_range(99) < 8) nb = $urandom_range(30, 35);
      run_merge_set(na, nb, $urandom_range(2), $urandom_range(99) >= 10);
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d merge results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sorted_list_merge.f =====
hw/rtl/slm_pkg.sv
hw/rtl/slm_ram.sv
hw/rtl/slm_datapath.sv
hw/rtl/slm_ctrl.sv
hw/rtl/sorted_list_merge.sv
dv/sorted_list_merge_test.sv
